FILE: rtl/clns_pkg.sv
package clns_pkg;

   // Width of the microcode step counter and number of programmed steps.
   localparam int STEP_W     = 5;
   localparam int STEP_COUNT = 25;

   typedef logic [STEP_W-1:0] step_type;

   // Entry points and branch targets in the microcode program.
   localparam step_type STEP_CHAR    = 5'd0;
   localparam step_type STEP_CMD     = 5'd2;
   localparam step_type STEP_CLEAR   = 5'd3;
   localparam step_type STEP_CURSOR  = 5'd5;
   localparam step_type STEP_ROW_BAD = 5'd7;
   localparam step_type STEP_SHL     = 5'd8;
   localparam step_type STEP_SHR     = 5'd10;
   localparam step_type STEP_INIT    = 5'd12;

   // Request modes.
   typedef enum logic [2:0] {
      MODE_CHAR   = 3'd0,
      MODE_CMD    = 3'd1,
      MODE_CLEAR  = 3'd2,
      MODE_CURSOR = 3'd3,
      MODE_SHL    = 3'd4,
      MODE_SHR    = 3'd5,
      MODE_INIT   = 3'd6
   } mode_type;

   // Pin event kinds.
   typedef enum logic [1:0] {
      DRIVE_WAIT  = 2'd0,
      DRIVE_SET   = 2'd1,
      DRIVE_PULSE = 2'd2
   } drive_type;

   // Where the data nibble of an event comes from.
   typedef enum logic [2:0] {
      NIB_CONST   = 3'd0,
      NIB_CHAR_HI = 3'd1,
      NIB_CHAR_LO = 3'd2,
      NIB_CMD     = 3'd3,
      NIB_ADDR_HI = 3'd4,
      NIB_ADDR_LO = 3'd5
   } nib_src_type;

   // Extra delay after an event, encoded.
   typedef enum logic [2:0] {
      WAIT_NONE   = 3'd0,
      WAIT_35     = 3'd1,
      WAIT_70     = 3'd2,
      WAIT_150    = 3'd3,
      WAIT_2000   = 3'd4,
      WAIT_5000   = 3'd5,
      WAIT_150000 = 3'd6
   } wait_code_type;

   localparam logic [7:0] ROW1_BASE = 8'h80;
   localparam logic [7:0] ROW2_BASE = 8'hC0;

   // One microcode control word.
   typedef struct packed {
      drive_type     drive;
      logic          rs;
      nib_src_type   nib_src;
      logic [3:0]    nib_const;
      wait_code_type wait_code;
      logic          last;
      logic          br_bad_row;
      step_type      br_target;
   } ctl_word_type;

   // Sequencer to datapath strobes.
   typedef struct packed {
      logic capture;
      logic emit;
   } seq_ctl_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic slot_free;
      logic bad_row;
   } dp_status_type;

   // Decode of the wait code to microseconds.
   function automatic logic [17:0] wait_value(wait_code_type code);
      logic [17:0] value;
      unique case (code)
         WAIT_NONE:   value = 18'd0;
         WAIT_35:     value = 18'd35;
         WAIT_70:     value = 18'd70;
         WAIT_150:    value = 18'd150;
         WAIT_2000:   value = 18'd2000;
         WAIT_5000:   value = 18'd5000;
         WAIT_150000: value = 18'd150000;
         default:     value = 18'd0;
      endcase
      return value;
   endfunction

endpackage

FILE: rtl/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer for a display in 4-bit mode.
// A request on the req_ channel (mode, char_code, command_nibble, row,
// column) is turned into a run of pin events on the rsp_ channel, one
// event per transaction: drive kind, RS level, data nibble D4..D7 and an
// extra wait in microseconds; rsp_last marks the final event of a request.
// A microcode table holds one control word per event; a step counter walks
// it, with a conditional jump for a cursor request on an invalid row.
// The request is registered in the step counter and the request field
// registers, and each event is registered in the output register; a cursor
// request on an invalid row first takes the jump. Events leave at one per
// cycle while the receiver does not stall; a request with the unused mode
// is taken and gives no event. req_ready is low while a request is in progress.
// When the receiver stalls, the event waits in the output register and the
// step counter holds but for a jump, which needs no free slot. The csr_ port
// writes the enable pulse time, kept for the pin driver. Reset (synchronous,
// active high) empties the block, sets the held RS and data levels to zero
// and the pulse time to one.
module char_lcd_nibble_sequencer
   import clns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_char_code,
   input  logic [3:0]  req_command_nibble,
   input  logic [1:0]  req_row,
   input  logic [5:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_drive,
   output logic        rsp_reg_select,
   output logic [3:0]  rsp_nibble,
   output logic [17:0] rsp_wait_us,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);

   logic          busy_ff, busy_in;
   step_type      step_ff, step_in;
   logic [9:0]    en_pulse_ff;
   ctl_word_type  ctl;
   step_type      entry_step;
   logic          entry_ok;
   seq_ctl_type   seq;
   dp_status_type status;
   logic          accept;
   logic          take_branch;

   clns_ucode_rom u_rom (
      .step       (step_ff),
      .mode       (req_mode),
      .ctl        (ctl),
      .entry_step (entry_step),
      .entry_ok   (entry_ok)
   );

   clns_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .seq                (seq),
      .req_char_code      (req_char_code),
      .req_command_nibble (req_command_nibble),
      .req_row            (req_row),
      .req_column         (req_column),
      .rsp_ready          (rsp_ready),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_drive          (rsp_drive),
      .rsp_reg_select     (rsp_reg_select),
      .rsp_nibble         (rsp_nibble),
      .rsp_wait_us        (rsp_wait_us),
      .rsp_last           (rsp_last)
   );

   // Enable pulse time register for the pin driver.
   always_ff @(posedge clock) begin
      if (reset) begin
         en_pulse_ff <= 10'd1;
      end else if (csr_wr_en) begin
         en_pulse_ff <= csr_wr_data;
      end
   end

   // Sequencer: a step issues its event when the output slot is free, or
   // jumps without an event when its branch condition holds.
   assign req_ready   = !busy_ff;
   assign accept      = req_valid && req_ready;
   assign take_branch = busy_ff && ctl.br_bad_row && status.bad_row;
   assign seq.capture = accept;
   assign seq.emit    = busy_ff && status.slot_free && !take_branch;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      priority if (accept) begin
         busy_in = entry_ok;
         step_in = entry_step;
      end else if (take_branch) begin
         step_in = ctl.br_target;
      end else if (seq.emit) begin
         if (ctl.last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + step_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_CHAR;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // A valid mode starts a sequence.
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept && entry_ok |=> busy_ff)
      else $error("request with a valid mode did not start a sequence");

   // The step counter never leaves the program while busy.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff < step_type'(STEP_COUNT)))
      else $error("step counter outside the microcode program");

   // The final event ends the sequence.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      seq.emit && ctl.last |=> !busy_ff && rsp_valid && rsp_last)
      else $error("final event did not end the sequence");

   // A wait-only event is always the final one of its request.
   a_wait_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_drive == DRIVE_WAIT) |-> rsp_last)
      else $error("wait-only event that is not final");

   // A register write lands in the pulse time register.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> en_pulse_ff == $past(csr_wr_data))
      else $error("enable pulse time write lost");

endmodule

FILE: rtl/clns_ucode_rom.sv
module clns_ucode_rom
   import clns_pkg::*;
(
   input  step_type     step,
   input  logic [2:0]   mode,
   output ctl_word_type ctl,
   output step_type     entry_step,
   output logic         entry_ok
);

   function automatic ctl_word_type cw(drive_type d, logic rs, nib_src_type src,
                                       logic [3:0] nib, wait_code_type w, logic last);
      ctl_word_type word;
      word.drive      = d;
      word.rs         = rs;
      word.nib_src    = src;
      word.nib_const  = nib;
      word.wait_code  = w;
      word.last       = last;
      word.br_bad_row = 1'b0;
      word.br_target  = STEP_ROW_BAD;
      return word;
   endfunction

   // Microcode program, one pin event per step.
   always_comb begin
      unique case (step)
         5'd0:  ctl = cw(DRIVE_PULSE, 1'b1, NIB_CHAR_HI, 4'h0, WAIT_NONE, 1'b0);
         5'd1:  ctl = cw(DRIVE_PULSE, 1'b1, NIB_CHAR_LO, 4'h0, WAIT_NONE, 1'b1);
         5'd2:  ctl = cw(DRIVE_PULSE, 1'b0, NIB_CMD, 4'h0, WAIT_NONE, 1'b1);
         5'd3:  ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h0, WAIT_NONE, 1'b0);
         5'd4:  ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h1, WAIT_70, 1'b1);
         5'd5: begin
            // Branches to the wait-only step when the row is not 1 or 2.
            ctl = cw(DRIVE_PULSE, 1'b0, NIB_ADDR_HI, 4'h0, WAIT_NONE, 1'b0);
            ctl.br_bad_row = 1'b1;
         end
         5'd6:  ctl = cw(DRIVE_PULSE, 1'b0, NIB_ADDR_LO, 4'h0, WAIT_2000, 1'b1);
         5'd7:  ctl = cw(DRIVE_WAIT, 1'b0, NIB_CONST, 4'h0, WAIT_2000, 1'b1);
         5'd8:  ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h1, WAIT_NONE, 1'b0);
         5'd9:  ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h8, WAIT_35, 1'b1);
         5'd10: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h1, WAIT_NONE, 1'b0);
         5'd11: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'hC, WAIT_35, 1'b1);
         5'd12: ctl = cw(DRIVE_SET, 1'b0, NIB_CONST, 4'h0, WAIT_150000, 1'b0);
         5'd13: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h3, WAIT_5000, 1'b0);
         5'd14: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h3, WAIT_150, 1'b0);
         5'd15: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h3, WAIT_NONE, 1'b0);
         5'd16: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h2, WAIT_NONE, 1'b0);
         5'd17: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h2, WAIT_NONE, 1'b0);
         5'd18: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h8, WAIT_NONE, 1'b0);
         5'd19: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h0, WAIT_NONE, 1'b0);
         5'd20: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'hC, WAIT_NONE, 1'b0);
         5'd21: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h0, WAIT_NONE, 1'b0);
         5'd22: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h6, WAIT_NONE, 1'b0);
         5'd23: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h0, WAIT_NONE, 1'b0);
         5'd24: ctl = cw(DRIVE_PULSE, 1'b0, NIB_CONST, 4'h1, WAIT_NONE, 1'b1);
         default: ctl = cw(DRIVE_WAIT, 1'b0, NIB_CONST, 4'h0, WAIT_NONE, 1'b1);
      endcase
   end

   // Entry point of each mode; the unused mode starts nothing.
   always_comb begin
      entry_ok = 1'b1;
      unique case (mode)
         MODE_CHAR:   entry_step = STEP_CHAR;
         MODE_CMD:    entry_step = STEP_CMD;
         MODE_CLEAR:  entry_step = STEP_CLEAR;
         MODE_CURSOR: entry_step = STEP_CURSOR;
         MODE_SHL:    entry_step = STEP_SHL;
         MODE_SHR:    entry_step = STEP_SHR;
         MODE_INIT:   entry_step = STEP_INIT;
         default: begin
            entry_step = STEP_CHAR;
            entry_ok   = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/clns_datapath.sv
module clns_datapath
   import clns_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_word_type  ctl,
   input  seq_ctl_type   seq,
   input  logic [7:0]    req_char_code,
   input  logic [3:0]    req_command_nibble,
   input  logic [1:0]    req_row,
   input  logic [5:0]    req_column,
   input  logic          rsp_ready,
   output dp_status_type status,
   output logic          rsp_valid,
   output logic [1:0]    rsp_drive,
   output logic          rsp_reg_select,
   output logic [3:0]    rsp_nibble,
   output logic [17:0]   rsp_wait_us,
   output logic          rsp_last
);

   logic [7:0]  char_ff;
   logic [3:0]  cmd_ff;
   logic [1:0]  row_ff;
   logic [5:0]  col_ff;
   logic        held_rs_ff, held_rs_in;
   logic [3:0]  held_nib_ff, held_nib_in;
   logic        valid_ff, valid_in;
   drive_type   drive_ff;
   logic        rs_ff;
   logic [3:0]  nib_ff;
   logic [17:0] wait_ff;
   logic        last_ff;
   logic [7:0]  addr;
   logic [3:0]  nib_sel;

   // Request fields held for the whole sequence.
   always_ff @(posedge clock) begin
      if (seq.capture) begin
         char_ff <= req_char_code;
         cmd_ff  <= req_command_nibble;
         row_ff  <= req_row;
         col_ff  <= req_column;
      end
   end

   // DDRAM address for the cursor command, wrapping in 8 bits.
   assign addr = ((row_ff == 2'd1) ? ROW1_BASE : ROW2_BASE) + {2'b00, col_ff} - 8'd1;

   assign status.bad_row   = (row_ff == 2'd0) || (row_ff == 2'd3);
   assign status.slot_free = !valid_ff || rsp_ready;

   // Nibble source selection.
   always_comb begin
      unique case (ctl.nib_src)
         NIB_CONST:   nib_sel = ctl.nib_const;
         NIB_CHAR_HI: nib_sel = char_ff[7:4];
         NIB_CHAR_LO: nib_sel = char_ff[3:0];
         NIB_CMD:     nib_sel = cmd_ff;
         NIB_ADDR_HI: nib_sel = addr[7:4];
         NIB_ADDR_LO: nib_sel = addr[3:0];
         default:     nib_sel = ctl.nib_const;
      endcase
   end

   // Held pin levels follow every event that drives the pins.
   always_comb begin
      held_rs_in  = held_rs_ff;
      held_nib_in = held_nib_ff;
      if (seq.emit && ctl.drive != DRIVE_WAIT) begin
         held_rs_in  = ctl.rs;
         held_nib_in = nib_sel;
      end
      valid_in = valid_ff;
      if (seq.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_rs_ff  <= 1'b0;
         held_nib_ff <= 4'h0;
         valid_ff    <= 1'b0;
      end else begin
         held_rs_ff  <= held_rs_in;
         held_nib_ff <= held_nib_in;
         valid_ff    <= valid_in;
      end
   end

   // Output register of the event channel.
   always_ff @(posedge clock) begin
      if (seq.emit) begin
         drive_ff <= ctl.drive;
         rs_ff    <= held_rs_in;
         nib_ff   <= held_nib_in;
         wait_ff  <= wait_value(ctl.wait_code);
         last_ff  <= ctl.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_drive      = drive_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_nibble     = nib_ff;
   assign rsp_wait_us    = wait_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: dv/char_lcd_nibble_sequencer_tb.sv
module char_lcd_nibble_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import clns_pkg::*;

   localparam int CLOCK_HALF_NS  = 6;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_OFF_LONG  = 300;
   localparam longint TIMEOUT_NS = 20_000_000;

   // Mode code that the block takes and drops.
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   // Command bytes sent as two nibbles.
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
   localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;

   // Extra delays in microseconds.
   localparam logic [17:0] DELAY_NONE_US    = 18'd0;
   localparam logic [17:0] DELAY_SHIFT_US   = 18'd35;
   localparam logic [17:0] DELAY_CLEAR_US   = 18'd70;
   localparam logic [17:0] DELAY_CURSOR_US  = 18'd2000;
   localparam logic [17:0] DELAY_WAKE1_US   = 18'd5000;
   localparam logic [17:0] DELAY_WAKE2_US   = 18'd150;
   localparam logic [17:0] DELAY_POWERUP_US = 18'd150000;

   // Pulsed nibbles of the power-up sequence, first one in the top bits.
   localparam logic [47:0] POWERUP_NIBBLES = {4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8,
                                              4'h0, 4'hC, 4'h0, 4'h6, 4'h0, 4'h1};

   typedef struct {
      logic [2:0] mode;
      logic [7:0] char_code;
      logic [3:0] command_nibble;
      logic [1:0] row;
      logic [5:0] column;
   } lcd_request_type;

   typedef struct {
      drive_type   drive;
      logic        reg_select;
      logic [3:0]  nibble;
      logic [17:0] wait_us;
      logic        last;
   } pin_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [7:0]  req_char_code = '0;
   logic [3:0]  req_command_nibble = '0;
   logic [1:0]  req_row = '0;
   logic [5:0]  req_column = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_drive;
   logic        rsp_reg_select;
   logic [3:0]  rsp_nibble;
   logic [17:0] rsp_wait_us;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;

   // Copy of the block's held pin levels.
   logic        model_rs;
   logic [3:0]  model_nibble;

   pin_event_type  request_events[$];
   pin_event_type  expected_events[$];
   int             mismatch_count = 0;
   bit             tx_idle = 1'b0;
   bit             rx_idle = 1'b0;
   int             hold_off_cycles = 0;

   char_lcd_nibble_sequencer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_char_code      (req_char_code),
      .req_command_nibble (req_command_nibble),
      .req_row            (req_row),
      .req_column         (req_column),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive          (rsp_drive),
      .rsp_reg_select     (rsp_reg_select),
      .rsp_nibble         (rsp_nibble),
      .rsp_wait_us        (rsp_wait_us),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Free-running clock.
   always begin
      #CLOCK_HALF_NS clock = 1'b1;
      #CLOCK_HALF_NS clock = 1'b0;
   end

   // One pin event of the current request; driving events update the held levels.
   task automatic add_pin_event(input drive_type drive, input logic rs,
                                input logic [3:0] nibble, input logic [17:0] wait_us);
      pin_event_type ev;
      if (drive != DRIVE_WAIT) begin
         model_rs     = rs;
         model_nibble = nibble;
      end
      ev.drive      = drive;
      ev.reg_select = model_rs;
      ev.nibble     = model_nibble;
      ev.wait_us    = wait_us;
      ev.last       = 1'b0;
      request_events.push_back(ev);
   endtask

   // A byte goes out as two pulsed nibbles, high first; the delay follows the low one.
   task automatic add_byte_events(input logic rs, input logic [7:0] value,
                                  input logic [17:0] wait_us);
      add_pin_event(DRIVE_PULSE, rs, value[7:4], DELAY_NONE_US);
      add_pin_event(DRIVE_PULSE, rs, value[3:0], wait_us);
   endtask

   // Works out the pin events of one accepted request and queues them.
   task automatic predict_pin_events(input lcd_request_type rq);
      logic [7:0] cursor_addr;
      pin_event_type ev;
      case (rq.mode)
         MODE_CHAR: begin
            add_byte_events(1'b1, rq.char_code, DELAY_NONE_US);
         end
         MODE_CMD: begin
            add_pin_event(DRIVE_PULSE, 1'b0, rq.command_nibble, DELAY_NONE_US);
         end
         MODE_CLEAR: begin
            add_byte_events(1'b0, CMD_CLEAR, DELAY_CLEAR_US);
         end
         MODE_CURSOR: begin
            if (rq.row == 2'd1 || rq.row == 2'd2) begin
               cursor_addr = ((rq.row == 2'd1) ? ROW1_BASE : ROW2_BASE)
                             + {2'b00, rq.column} - 8'd1;
               add_byte_events(1'b0, cursor_addr, DELAY_CURSOR_US);
            end else begin
               // A bad row only waits, reporting the held levels.
               add_pin_event(DRIVE_WAIT, 1'b0, 4'h0, DELAY_CURSOR_US);
            end
         end
         MODE_SHL: begin
            add_byte_events(1'b0, CMD_SHIFT_LEFT, DELAY_SHIFT_US);
         end
         MODE_SHR: begin
            add_byte_events(1'b0, CMD_SHIFT_RIGHT, DELAY_SHIFT_US);
         end
         MODE_INIT: begin
            add_pin_event(DRIVE_SET, 1'b0, 4'h0, DELAY_POWERUP_US);
            for (int i = 0; i < 12; i++) begin
               add_pin_event(DRIVE_PULSE, 1'b0, POWERUP_NIBBLES[4*(11-i) +: 4],
                             (i == 0) ? DELAY_WAKE1_US :
                             (i == 1) ? DELAY_WAKE2_US : DELAY_NONE_US);
            end
         end
         default: begin
         end
      endcase
      // Mark the final event and hand the burst over to the checker.
      if (request_events.size() > 0) begin
         ev = request_events[request_events.size()-1];
         ev.last = 1'b1;
         request_events[request_events.size()-1] = ev;
      end
      foreach (request_events[i]) expected_events.push_back(request_events[i]);
      request_events.delete();
   endtask

   // Sends one request; the prediction is made at the accepting edge.
   task automatic send_request(input lcd_request_type rq);
      int gap;
      gap = tx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= rq.mode;
      req_char_code      <= rq.char_code;
      req_command_nibble <= rq.command_nibble;
      req_row            <= rq.row;
      req_column         <= rq.column;
      do @(posedge clock); while (!req_ready);
      predict_pin_events(rq);
   endtask

   function automatic lcd_request_type make_request(input logic [2:0] mode,
                                                    input logic [7:0] ch,
                                                    input logic [3:0] cmd,
                                                    input logic [1:0] row,
                                                    input logic [5:0] column);
      lcd_request_type rq;
      rq.mode           = mode;
      rq.char_code      = ch;
      rq.command_nibble = cmd;
      rq.row            = row;
      rq.column         = column;
      return rq;
   endfunction

   // Random request: mostly the six short modes, some power-up runs and dropped codes.
   function automatic lcd_request_type random_request();
      int pick;
      logic [2:0] mode;
      logic [5:0] column;
      pick = $urandom_range(0, 99);
      if (pick < 8) mode = MODE_INIT;
      else if (pick < 12) mode = MODE_UNUSED;
      else mode = 3'($urandom_range(0, 5));
      column = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 40));
      return make_request(mode, 8'($urandom), 4'($urandom), 2'($urandom_range(0, 3)),
                          column);
   endfunction

   // Stops offering, waits until every expected event has arrived, then lets the block settle.
   task automatic wait_for_events();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pulse_width(input logic [9:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Field extremes, every mode, bad rows, wrapping columns and the dropped mode code.
   task automatic test_directed_cases();
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      send_request(make_request(MODE_CHAR, 8'h00, 4'h0, 2'd0, 6'd0));
      send_request(make_request(MODE_CHAR, 8'hFF, 4'hF, 2'd3, 6'd63));
      send_request(make_request(MODE_CHAR, 8'h5A, 4'h0, 2'd1, 6'd1));
      send_request(make_request(MODE_CMD, 8'hFF, 4'h0, 2'd0, 6'd0));
      send_request(make_request(MODE_CMD, 8'h00, 4'hF, 2'd3, 6'd63));
      send_request(make_request(MODE_CLEAR, 8'h00, 4'h0, 2'd0, 6'd0));
      send_request(make_request(MODE_CURSOR, 8'h00, 4'h0, 2'd1, 6'd1));
      send_request(make_request(MODE_CURSOR, 8'h00, 4'h0, 2'd2, 6'd40));
      send_request(make_request(MODE_CURSOR, 8'h00, 4'h0, 2'd1, 6'd0));
      send_request(make_request(MODE_CURSOR, 8'h00, 4'h0, 2'd2, 6'd63));
      send_request(make_request(MODE_CURSOR, 8'h00, 4'h0, 2'd0, 6'd5));
      send_request(make_request(MODE_SHL, 8'h00, 4'h0, 2'd0, 6'd0));
      send_request(make_request(MODE_SHR, 8'h00, 4'h0, 2'd0, 6'd0));
      send_request(make_request(MODE_INIT, 8'h00, 4'h0, 2'd0, 6'd0));
      send_request(make_request(MODE_CURSOR, 8'hFF, 4'hF, 2'd3, 6'd10));
      send_request(make_request(MODE_UNUSED, 8'hFF, 4'hF, 2'd3, 6'd63));
      send_request(make_request(MODE_CHAR, 8'hC3, 4'h0, 2'd0, 6'd0));
      send_request(make_request(MODE_CURSOR, 8'h00, 4'h0, 2'd3, 6'd40));
      wait_for_events();
   endtask

   // Pulse width at its extremes and beyond, with traffic under each setting.
   task automatic test_pulse_width_settings();
      logic [9:0] settings[4];
      settings[0] = 10'd0;
      settings[1] = 10'd1000;
      settings[2] = 10'd1023;
      settings[3] = 10'($urandom_range(0, 1000));
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      foreach (settings[i]) begin
         wait_for_events();
         write_pulse_width(settings[i]);
         repeat (5) send_request(random_request());
      end
      wait_for_events();
   endtask

   // Random requests, with idling on either side switched per stretch.
   task automatic test_random_traffic(input int n_items);
      int sent;
      lcd_request_type rq;
      sent = 0;
      while (sent < n_items) begin
         if (sent % 25 == 0) begin
            tx_idle = 1'($urandom_range(0, 1));
            rx_idle = 1'($urandom_range(0, 1));
         end
         rq = random_request();
         send_request(rq);
         if (rq.mode != MODE_UNUSED) sent++;
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming, then a full drain, then idling traffic.
   task automatic test_output_backpressure();
      wait_for_events();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_off_cycles = HOLD_OFF_LONG;
      repeat (20) send_request(random_request());
      wait_for_events();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (10) send_request(random_request());
      wait_for_events();
   endtask

   // Receiver: a random stall before each transaction when idling is on, or a long hold-off when requested.
   initial begin : event_receiver
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = rx_idle ? $urandom_range(0, 19) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && hold_off_cycles == 0);
      end
   end

   // Compares each accepted pin event with the oldest expected one.
   always @(posedge clock) begin : event_checker
      pin_event_type ev;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected event drive=%0d rs=%0d nibble=%h wait=%0d last=%0d",
                     $time, rsp_drive, rsp_reg_select, rsp_nibble, rsp_wait_us, rsp_last);
         end else begin
            ev = expected_events.pop_front();
            if (rsp_drive !== ev.drive) begin
               mismatch_count++;
               $display("%0t: drive expected %0d actual %0d", $time, ev.drive, rsp_drive);
            end
            if (rsp_reg_select !== ev.reg_select) begin
               mismatch_count++;
               $display("%0t: reg_select expected %0d actual %0d",
                        $time, ev.reg_select, rsp_reg_select);
            end
            if (rsp_nibble !== ev.nibble) begin
               mismatch_count++;
               $display("%0t: nibble expected %h actual %h", $time, ev.nibble, rsp_nibble);
            end
            if (rsp_wait_us !== ev.wait_us) begin
               mismatch_count++;
               $display("%0t: wait_us expected %0d actual %0d", $time, ev.wait_us, rsp_wait_us);
            end
            if (rsp_last !== ev.last) begin
               mismatch_count++;
               $display("%0t: last expected %0d actual %0d", $time, ev.last, rsp_last);
            end
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      model_rs       = 1'b0;
      model_nibble   = 4'h0;
      @(posedge clock);
      test_directed_cases();
      test_pulse_width_settings();
      test_random_traffic(125);
      test_output_backpressure();
      test_random_traffic(110);
      wait_for_events();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #TIMEOUT_NS;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
